@@ design/pnt_pkg.sv @@
// Shared constants, types and state codes for the powerful-number test.
package pnt_pkg;

  // Field and value widths.
  localparam int LO_W  = 64;
  localparam int HI_W  = 13;
  localparam int VAL_W = LO_W + HI_W;
  localparam int P_W   = 16;
  localparam int SQ_W  = 2 * P_W;

  // Trial divisors run over 2 and the odd numbers up to the largest prime below 2^16.
  localparam logic [P_W-1:0] FIRST_CAND = P_W'(2);
  localparam logic [P_W-1:0] LAST_CAND  = P_W'(65521);

  // Long divider: a fixed number of dividend bits is retired each cycle.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VAL_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_PAD_W = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Digit-by-digit root extraction widths.
  localparam int ROOT_Y_W  = (VAL_W + 1) / 2;
  localparam int ROOT_Y2_W = 2 * ((VAL_W + 2) / 3);
  localparam int ROOT_B_W  = ROOT_Y2_W + 4;
  localparam int ROOT_S_W  = $clog2(VAL_W);
  localparam logic [ROOT_S_W-1:0] SQ_TOP   = ROOT_S_W'(((VAL_W - 1) / 2) * 2);
  localparam logic [ROOT_S_W-1:0] CUBE_TOP = ROOT_S_W'(((VAL_W - 1) / 3) * 3);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_FINISH
  } state_t;

  // Divider result toward the sequencer.
  typedef struct packed {
    logic             done;
    logic             rem_zero;
    logic [VAL_W-1:0] quot;
  } div_res_t;

  // Root unit result toward the sequencer.
  typedef struct packed {
    logic done;
    logic perfect;
  } root_res_t;

endpackage

@@ design/pnt_in_if.sv @@
// Input channel: the value to test, split into a low and a high part.
interface pnt_in_if;
  logic                     valid;
  logic                     ready;
  logic [pnt_pkg::LO_W-1:0] value_low;
  logic [pnt_pkg::HI_W-1:0] value_high;

  modport source (output valid, value_low, value_high, input ready);
  modport sink   (input valid, value_low, value_high, output ready);
endinterface

@@ design/pnt_out_if.sv @@
// Output channel: one flag per tested value.
interface pnt_out_if;
  logic valid;
  logic ready;
  logic is_powerful_flag;

  modport source (output valid, is_powerful_flag, input ready);
  modport sink   (input valid, is_powerful_flag, output ready);
endinterface

@@ design/powerful_number_test_top.sv @@
// Powerful-number test: trial-division sequencer over a shared divider and root unit.
// Values 0 and 1 go straight to the finish state; otherwise each trial divisor costs one
// division plus one more each time it divides the value, and when all 32761 divisors are
// walked, a square root test and, if needed, a cube root test follow.
// Throughput: one value at a time; ready is high only while idle, and the result
// register frees the input side. Synchronous reset clears control; no tables to fill.
module powerful_number_test_top (
  input  logic        clk,
  input  logic        rst,
  pnt_in_if.sink      in_ch,
  pnt_out_if.source   out_ch
);

  localparam logic [pnt_pkg::P_W-1:0] P_TWO = pnt_pkg::P_W'(2);

  pnt_pkg::state_t                state;
  pnt_pkg::state_t                state_next;
  logic [pnt_pkg::VAL_W-1:0]      val;
  logic [pnt_pkg::VAL_W-1:0]      val_in;
  logic [pnt_pkg::P_W-1:0]        p;
  logic [pnt_pkg::SQ_W-1:0]       psq;
  logic [1:0]                     cnt;
  logic                           cube;
  logic                           result;
  logic                           out_valid;
  logic                           out_flag;
  logic                           in_ready;
  logic                           accept;
  logic                           div_start;
  logic                           root_start;
  logic                           load_ok;
  logic                           too_big;
  pnt_pkg::div_res_t              div_res;
  pnt_pkg::root_res_t             root_res;

  assign val_in = {in_ch.value_high, in_ch.value_low};
  assign accept = in_ch.valid && in_ready;
  // Remaining cofactor is below the square of the current divisor.
  assign too_big = (val[pnt_pkg::VAL_W-1:pnt_pkg::LO_W] == '0) &&
                   (pnt_pkg::LO_W'(psq) > val[pnt_pkg::LO_W-1:0]);

  pnt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (val),
    .divisor  (p),
    .res      (div_res)
  );

  pnt_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .cube  (cube),
    .value (val),
    .res   (root_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pnt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (val_in <= pnt_pkg::VAL_W'(1)) ? pnt_pkg::S_FINISH : pnt_pkg::S_SQUARE;
        end
      end
      pnt_pkg::S_SQUARE: state_next = pnt_pkg::S_CHECK;
      pnt_pkg::S_CHECK:  state_next = too_big ? pnt_pkg::S_FINISH : pnt_pkg::S_DIV_GO;
      pnt_pkg::S_DIV_GO: state_next = pnt_pkg::S_DIV_WAIT;
      pnt_pkg::S_DIV_WAIT: begin
        if (div_res.done) begin
          priority if (div_res.rem_zero) begin
            state_next = pnt_pkg::S_DIV_GO;
          end else if (cnt == 2'd1) begin
            state_next = pnt_pkg::S_FINISH;
          end else if (cnt == 2'd2 && val == pnt_pkg::VAL_W'(1)) begin
            state_next = pnt_pkg::S_FINISH;
          end else if (p == pnt_pkg::LAST_CAND) begin
            state_next = pnt_pkg::S_ROOT_GO;
          end else begin
            state_next = pnt_pkg::S_SQUARE;
          end
        end
      end
      pnt_pkg::S_ROOT_GO: state_next = pnt_pkg::S_ROOT_WAIT;
      pnt_pkg::S_ROOT_WAIT: begin
        if (root_res.done) begin
          state_next = (root_res.perfect || cube) ? pnt_pkg::S_FINISH : pnt_pkg::S_ROOT_GO;
        end
      end
      pnt_pkg::S_FINISH: state_next = load_ok ? pnt_pkg::S_IDLE : pnt_pkg::S_FINISH;
      default: state_next = pnt_pkg::S_IDLE;
    endcase
  end

  // State decodes.
  always_comb begin
    in_ready   = (state == pnt_pkg::S_IDLE);
    div_start  = (state == pnt_pkg::S_DIV_GO);
    root_start = (state == pnt_pkg::S_ROOT_GO);
    load_ok    = (state == pnt_pkg::S_FINISH) && (!out_valid || out_ch.ready);
  end

  // Control registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pnt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load_ok || (out_valid && !out_ch.ready);
    end
  end

  // Working value, divisor, its square, factor count, root mode, result and output flag.
  always_ff @(posedge clk) begin
    if (load_ok) begin
      out_flag <= result;
    end
    unique case (state)
      pnt_pkg::S_IDLE: begin
        if (accept) begin
          val    <= val_in;
          result <= (val_in == pnt_pkg::VAL_W'(1));
          p      <= pnt_pkg::FIRST_CAND;
          cnt    <= 2'd0;
          cube   <= 1'b0;
        end
      end
      pnt_pkg::S_SQUARE: psq <= {{pnt_pkg::P_W{1'b0}}, p} * {{pnt_pkg::P_W{1'b0}}, p};
      pnt_pkg::S_CHECK: begin
        if (too_big) begin
          result <= 1'b0;
        end
      end
      pnt_pkg::S_DIV_WAIT: begin
        if (div_res.done) begin
          priority if (div_res.rem_zero) begin
            val <= div_res.quot;
            cnt <= (cnt == 2'd0) ? 2'd1 : 2'd2;
          end else if (cnt == 2'd1) begin
            result <= 1'b0;
          end else if (cnt == 2'd2 && val == pnt_pkg::VAL_W'(1)) begin
            result <= 1'b1;
          end else begin
            cnt <= 2'd0;
            p   <= (p == pnt_pkg::FIRST_CAND) ? p + 1'b1 : p + P_TWO;
          end
        end
      end
      pnt_pkg::S_ROOT_WAIT: begin
        if (root_res.done) begin
          priority if (root_res.perfect) begin
            result <= 1'b1;
          end else if (!cube) begin
            cube <= 1'b1;
          end else begin
            result <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid;
  assign out_ch.is_powerful_flag = out_flag;

  // A division is never started with a divisor below two.
  a_div_divisor: assert property (@(posedge clk) disable iff (rst)
    div_start |-> p >= pnt_pkg::FIRST_CAND)
    else $error("division started with a divisor below two");

  // Trial division only runs on a cofactor above one.
  a_check_val: assert property (@(posedge clk) disable iff (rst)
    state == pnt_pkg::S_CHECK |-> val > pnt_pkg::VAL_W'(1))
    else $error("trial division on a cofactor of zero or one");

  // A factor seen exactly once ends the test with a zero result.
  a_single_factor: assert property (@(posedge clk) disable iff (rst)
    (state == pnt_pkg::S_DIV_WAIT && div_res.done && !div_res.rem_zero && cnt == 2'd1)
    |=> (state == pnt_pkg::S_FINISH && !result))
    else $error("single prime factor not reported as not powerful");

  // A result beat appears only out of the finish state.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == pnt_pkg::S_FINISH)
    else $error("result beat raised outside the finish state");

endmodule

@@ design/pnt_div.sv @@
// Multi-cycle long divider: value by a 16-bit divisor, quotient and a zero-remainder flag.
module pnt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pnt_pkg::VAL_W-1:0]  dividend,
  input  logic [pnt_pkg::P_W-1:0]    divisor,
  output pnt_pkg::div_res_t          res
);

  logic                                busy;
  logic                                done;
  logic [pnt_pkg::DIV_CNT_W-1:0]       cnt;
  logic [pnt_pkg::DIV_PAD_W-1:0]       num;
  logic [pnt_pkg::DIV_PAD_W-1:0]       quo;
  logic [pnt_pkg::P_W-1:0]             rem;
  logic [pnt_pkg::P_W-1:0]             dvs;
  logic [pnt_pkg::DIV_PAD_W-1:0]       num_next;
  logic [pnt_pkg::DIV_PAD_W-1:0]       quo_next;
  logic [pnt_pkg::P_W-1:0]             rem_next;

  // Retire one group of dividend bits by restoring compare and subtract.
  always_comb begin
    logic [pnt_pkg::P_W:0] t;
    rem_next = rem;
    num_next = num;
    quo_next = quo;
    for (int k = 0; k < pnt_pkg::DIV_BITS; k++) begin
      t        = {rem_next, num_next[pnt_pkg::DIV_PAD_W-1]};
      num_next = num_next << 1;
      if (t >= {1'b0, dvs}) begin
        t        = t - {1'b0, dvs};
        quo_next = {quo_next[pnt_pkg::DIV_PAD_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[pnt_pkg::DIV_PAD_W-2:0], 1'b0};
      end
      rem_next = t[pnt_pkg::P_W-1:0];
    end
  end

  // Control: busy until the step counter reaches its last step, then a one-cycle done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == pnt_pkg::DIV_CNT_W'(pnt_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= {{(pnt_pkg::DIV_PAD_W - pnt_pkg::VAL_W){1'b0}}, dividend};
      quo <= '0;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      num <= num_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign res.done     = done;
  assign res.rem_zero = (rem == '0);
  assign res.quot     = quo[pnt_pkg::VAL_W-1:0];

endmodule

@@ design/pnt_root.sv @@
// Exact integer square or cube root by digit recurrence; flags a perfect power.
module pnt_root (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      cube,
  input  logic [pnt_pkg::VAL_W-1:0] value,
  output pnt_pkg::root_res_t        res
);

  logic                              busy;
  logic                              phase;
  logic                              done;
  logic                              perfect;
  logic                              mode;
  logic [pnt_pkg::ROOT_S_W-1:0]      s;
  logic [pnt_pkg::VAL_W-1:0]         x;
  logic [pnt_pkg::ROOT_Y_W-1:0]      y;
  logic [pnt_pkg::ROOT_Y2_W-1:0]     y2;
  logic [pnt_pkg::ROOT_B_W-1:0]      b;
  logic [pnt_pkg::ROOT_Y_W-1:0]      y_dbl;
  logic [pnt_pkg::ROOT_Y2_W-1:0]     y2_dbl;
  logic [pnt_pkg::ROOT_B_W-1:0]      sum;
  logic [pnt_pkg::ROOT_B_W-1:0]      b_next;
  logic [pnt_pkg::VAL_W-1:0]         x_top;
  logic [pnt_pkg::VAL_W-1:0]         b_wide;
  logic                              take;
  logic [pnt_pkg::VAL_W-1:0]         x_next;

  // First half of a step: double the partial root and form the increment.
  always_comb begin
    y_dbl  = y << 1;
    y2_dbl = y2 << 2;
    sum    = pnt_pkg::ROOT_B_W'(y2_dbl) + pnt_pkg::ROOT_B_W'(y_dbl);
    if (mode) begin
      b_next = (sum << 1) + sum + pnt_pkg::ROOT_B_W'(1);
    end else begin
      b_next = (pnt_pkg::ROOT_B_W'(y_dbl) << 1) + pnt_pkg::ROOT_B_W'(1);
    end
  end

  // Second half: compare the shifted remainder and subtract when it fits.
  always_comb begin
    x_top  = x >> s;
    b_wide = pnt_pkg::VAL_W'(b);
    take   = (x_top >= b_wide);
    x_next = take ? (x - (b_wide << s)) : x;
  end

  // Control and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && phase && s == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x     <= value;
      y     <= '0;
      y2    <= '0;
      mode  <= cube;
      phase <= 1'b0;
      s     <= cube ? pnt_pkg::CUBE_TOP : pnt_pkg::SQ_TOP;
    end else if (busy) begin
      if (!phase) begin
        y     <= y_dbl;
        y2    <= y2_dbl;
        b     <= b_next;
        phase <= 1'b1;
      end else begin
        x <= x_next;
        if (take) begin
          y  <= y + 1'b1;
          y2 <= y2 + pnt_pkg::ROOT_Y2_W'({y, 1'b1});
        end
        perfect <= (x_next == '0);
        phase   <= 1'b0;
        s       <= s - (mode ? pnt_pkg::ROOT_S_W'(3) : pnt_pkg::ROOT_S_W'(2));
      end
    end
  end

  assign res.done    = done;
  assign res.perfect = perfect;

endmodule

@@ verif/pnt_checker.sv @@
// Scoreboard for the powerful-number test: predicts each flag and compares it with the block.
module pnt_checker (
  input  logic clk,
  input  logic rst,
  pnt_in_if    in_ch,
  pnt_out_if   out_ch,
  output int   errors,
  output int   pending
);

  localparam int NPRIMES = 6542;

  int unsigned prime_list[NPRIMES];
  bit          flag_q[$];
  int          mismatches;

  // Build the table of primes below 2^16 with a sieve.
  initial begin
    bit composite[65536];
    int n;
    n = 0;
    for (int i = 2; i < 65536; i++) begin
      if (!composite[i]) begin
        prime_list[n] = i;
        n++;
        for (int j = i * i; j < 65536 && i < 256; j += i) composite[j] = 1'b1;
      end
    end
  end

  // Exact k-th root search over [0, bound).
  function automatic bit is_exact_power(bit [pnt_pkg::VAL_W-1:0] v, int k, bit [63:0] bound);
    bit [63:0]  a;
    bit [63:0]  b;
    bit [63:0]  mid;
    bit [127:0] pw;
    a = 0;
    b = bound;
    while (a < b) begin
      mid = a + ((b - a) >> 1);
      pw  = 1;
      for (int i = 0; i < k; i++) pw = pw * mid;
      if (pw == 128'(v)) return 1'b1;
      if (pw < 128'(v)) a = mid + 1;
      else b = mid;
    end
    return 1'b0;
  endfunction

  // Trial division over the prime table, then the root tests on what is left.
  function automatic bit powerful_flag(bit [pnt_pkg::VAL_W-1:0] v);
    bit [pnt_pkg::VAL_W-1:0] p;
    bit [pnt_pkg::VAL_W-1:0] two64;
    two64 = pnt_pkg::VAL_W'(1) << 64;
    if (v <= 1) return v[0];
    for (int i = 0; i < NPRIMES; i++) begin
      p = pnt_pkg::VAL_W'(prime_list[i]);
      if (v < two64 && p * p > v) return 1'b0;
      if (v % p == 0) begin
        v = v / p;
        if (v % p != 0) return 1'b0;
        while (v % p == 0) v = v / p;
        if (v == 1) return 1'b1;
      end
    end
    return is_exact_power(v, 2, 64'd1 << 39) || is_exact_power(v, 3, 64'd1 << 26)
        || is_exact_power(v, 4, 64'd1 << 20);
  endfunction

  // Predict on every input beat and compare on every output beat.
  always @(posedge clk) begin
    bit want;
    if (rst) begin
      flag_q.delete();
      errors     <= 0;
      pending    <= 0;
      mismatches = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        flag_q.push_back(powerful_flag({in_ch.value_high, in_ch.value_low}));
      if (out_ch.valid && out_ch.ready) begin
        if (flag_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result beat with no expected flag");
        end else begin
          want = flag_q.pop_front();
          if (want !== out_ch.is_powerful_flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: is_powerful_flag expected %0d, got %0d",
                       want, out_ch.is_powerful_flag);
          end
        end
      end
      errors  <= mismatches;
      pending <= flag_q.size();
    end
  end
endmodule

@@ verif/tb_powerful_number_test_top.sv @@
// Testbench top for the powerful-number test: clock, reset, stimulus and verdict.
module tb_powerful_number_test_top;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   tx_idle;
  int   rx_idle;

  pnt_in_if  in_ch ();
  pnt_out_if out_ch ();

  powerful_number_test_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  pnt_checker chk (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at the current rate.
  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(0, 99) >= rx_idle);
  end

  // Hard stop in case the block hangs.
  initial begin
    #30000000;
    $display("Some tests failed");
    $finish;
  end

  // Send one value and hold it until the beat is taken.
  task automatic send_value(bit [pnt_pkg::VAL_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value_low  <= v[pnt_pkg::LO_W-1:0];
    in_ch.value_high <= v[pnt_pkg::VAL_W-1:pnt_pkg::LO_W];
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Product of small prime powers; optionally the product is multiplied by one more of the primes.
  function automatic bit [pnt_pkg::VAL_W-1:0] small_prime_product(bit spoil);
    int unsigned ps[9] = '{2, 3, 5, 7, 11, 13, 17, 19, 23};
    bit [127:0]  v;
    bit [127:0]  t;
    int          e;
    v = 1;
    foreach (ps[i]) begin
      e = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(2, 5);
      t = v;
      for (int j = 0; j < e; j++) t = t * ps[i];
      if (t < (128'd1 << pnt_pkg::VAL_W)) v = t;
    end
    if (spoil) begin
      t = v * ps[$urandom_range(0, 8)];
      if (t < (128'd1 << pnt_pkg::VAL_W)) v = t;
    end
    return pnt_pkg::VAL_W'(v);
  endfunction

  // Random mix: small-prime products (some spoiled), small values and wide values with a single 2.
  task automatic random_phase(int count);
    bit [pnt_pkg::VAL_W-1:0] v;
    int                      pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        v = small_prime_product($urandom_range(0, 9) < 3);
      end else if (pick < 70) begin
        v = pnt_pkg::VAL_W'($urandom_range(0, 100000));
      end else begin
        v = pnt_pkg::VAL_W'({$urandom(), $urandom(), $urandom()});
        v[1:0] = 2'b10;
      end
      send_value(v);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    bit [pnt_pkg::VAL_W-1:0] directed[$];
    int                      waited;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.value_low  = '0;
    in_ch.value_high = '0;
    tx_idle          = 32;
    rx_idle          = 74;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed values: zero, one, small primes and squares, the extremes of both fields,
    // and the fourth power of a prime just above the table, which walks every divisor.
    directed = '{0, 1, 2, 3, 4, 5, 8, 12, 36, 49, 72, 97, 65521, 63001,
                 {pnt_pkg::VAL_W{1'b1}}, pnt_pkg::VAL_W'(1) << 64,
                 pnt_pkg::VAL_W'(1) << 76,
                 {13'd1, 64'h0004_0006_0004_0001}};
    foreach (directed[i]) send_value(directed[i]);

    // Hold off until every expected flag has come back.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    random_phase(41);
    tx_idle = 74;
    rx_idle = 32;
    random_phase(41);
    tx_idle = 0;
    rx_idle = 0;
    random_phase(40);
    in_ch.valid <= 1'b0;

    // Drain, then keep the clock running for any stray beat.
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 2000000);
    repeat (50) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/pnt_pkg.sv
design/pnt_in_if.sv
design/pnt_out_if.sv
design/pnt_div.sv
design/pnt_root.sv
design/powerful_number_test_top.sv
verif/pnt_checker.sv
verif/tb_powerful_number_test_top.sv
